FILE: hdl/scp_pkg.sv
// Shared constants and types for the spectral class code packer.
`default_nettype none
package scp_pkg;

    // Longest text prefix in which a luminosity mark may start
    localparam int MAX_CHARS = 13;
    localparam int POS_W     = $clog2(MAX_CHARS + 1);

    // Parse phases: what the next character means
    localparam logic [3:0] PH_FIRST = 4'd0;
    localparam logic [3:0] PH_SD    = 4'd1;
    localparam logic [3:0] PH_CLASS = 4'd2;
    localparam logic [3:0] PH_W     = 4'd3;
    localparam logic [3:0] PH_SUB   = 4'd4;
    localparam logic [3:0] PH_SCAN  = 4'd5;
    localparam logic [3:0] PH_I     = 4'd6;
    localparam logic [3:0] PH_II    = 4'd7;
    localparam logic [3:0] PH_IA    = 4'd8;
    localparam logic [3:0] PH_V     = 4'd9;
    localparam logic [3:0] PH_DONE  = 4'd10;

    // Class codes
    localparam logic [7:0] CLS_O       = 8'd0;
    localparam logic [7:0] CLS_B       = 8'd1;
    localparam logic [7:0] CLS_A       = 8'd2;
    localparam logic [7:0] CLS_F       = 8'd3;
    localparam logic [7:0] CLS_G       = 8'd4;
    localparam logic [7:0] CLS_K       = 8'd5;
    localparam logic [7:0] CLS_M       = 8'd6;
    localparam logic [7:0] CLS_R       = 8'd7;
    localparam logic [7:0] CLS_S       = 8'd8;
    localparam logic [7:0] CLS_N       = 8'd9;
    localparam logic [7:0] CLS_WC      = 8'd10;
    localparam logic [7:0] CLS_WN      = 8'd11;
    localparam logic [7:0] CLS_DWARF   = 8'd16;
    localparam logic [7:0] CLS_UNKNOWN = 8'd255;

    // Luminosity codes
    localparam logic [2:0] LUM_IA0 = 3'd0;
    localparam logic [2:0] LUM_IA  = 3'd1;
    localparam logic [2:0] LUM_IB  = 3'd2;
    localparam logic [2:0] LUM_II  = 3'd3;
    localparam logic [2:0] LUM_III = 3'd4;
    localparam logic [2:0] LUM_IV  = 3'd5;
    localparam logic [2:0] LUM_V   = 3'd6;
    localparam logic [2:0] LUM_VI  = 3'd7;

    // Parser state carried from one character to the next
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [3:0]       phase;
        logic [7:0]       cls;
        logic [3:0]       sub;
        logic [2:0]       lum;
        logic             decided;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        pos:     '0,
        phase:   PH_FIRST,
        cls:     CLS_UNKNOWN,
        sub:     4'd0,
        lum:     LUM_V,
        decided: 1'b0
    };

endpackage
`default_nettype wire

FILE: hdl/scp_char_if.sv
// Input channel: one text character word per handshake.
`default_nettype none
interface scp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       end_of_string;

    modport source (output valid, text_char, end_of_string, input ready);
    modport sink   (input valid, text_char, end_of_string, output ready);
endinterface
`default_nettype wire

FILE: hdl/scp_code_if.sv
// Output channel: one packed spectral type word per handshake.
`default_nettype none
interface scp_code_if;
    logic        valid;
    logic        ready;
    logic [15:0] packed_type;

    modport source (output valid, packed_type, input ready);
    modport sink   (input valid, packed_type, output ready);
endinterface
`default_nettype wire

FILE: hdl/spectral_class_code_packer_top.sv
// Top level: input register, character parser and result register.
// A last character goes from the input register through the parser into the result
// register, which presents the result word until it is taken.
// Throughput: one character per cycle; the parser state updates once per character.
// A result waiting in the output register stalls input only when the next last
// character reaches the parser while the output is still held.
// Reset (i_rst_n low, synchronous) empties both registers and restarts the parse.
`default_nettype none
module spectral_class_code_packer_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    scp_char_if.sink    i_char,
    scp_code_if.source  o_code
);

    logic                  r_in_valid;
    logic [7:0]            r_in_char;
    logic                  r_in_eos;
    scp_pkg::t_parse_state r_state;
    scp_pkg::t_parse_state n_state;
    logic                  r_out_valid;
    logic [15:0]           r_out_code;
    logic [15:0]           n_code;
    logic                  w_advance;

    // Parser step for the registered character
    scp_parse u_parse (
        .i_state (r_state),
        .i_char  (r_in_char),
        .o_state (n_state),
        .o_code  (n_code)
    );

    // Handshake: a last character needs the output slot free or draining
    assign w_advance    = r_in_valid && (!r_in_eos || !r_out_valid || o_code.ready);
    assign i_char.ready = !r_in_valid || w_advance;
    assign o_code.valid       = r_out_valid;
    assign o_code.packed_type = r_out_code;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_in_char <= i_char.text_char;
            r_in_eos  <= i_char.end_of_string;
        end
    end

    // Parser state: restarts after each last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scp_pkg::PARSE_RESET;
        end else if (w_advance) begin
            r_state <= r_in_eos ? scp_pkg::PARSE_RESET : n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_eos) begin
            r_out_valid <= 1'b1;
        end else if (o_code.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_eos) begin
            r_out_code <= n_code;
        end
    end

`ifndef SYNTH
    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !r_out_valid)
        else $error("result valid after reset");

    // White dwarf carries no subclass or luminosity
    a_dwarf_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.cls == scp_pkg::CLS_DWARF |-> (r_state.sub == 4'd0 &&
            r_state.lum == scp_pkg::LUM_IA0 && r_state.phase == scp_pkg::PH_DONE))
        else $error("white dwarf state inconsistent");

    // Position saturates at the scan limit
    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pos <= scp_pkg::POS_W'(scp_pkg::MAX_CHARS))
        else $error("character position beyond limit");

    // Fixed luminosity never re-enters the scan
    a_decided_no_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.decided |-> (r_state.phase != scp_pkg::PH_SCAN &&
            r_state.phase != scp_pkg::PH_I && r_state.phase != scp_pkg::PH_V))
        else $error("scan active after luminosity fixed");
`endif

endmodule
`default_nettype wire

FILE: hdl/scp_parse.sv
// Next-state and packed-code logic of the parser for one character.
`default_nettype none
module scp_parse (
    input  wire scp_pkg::t_parse_state i_state,
    input  wire logic [7:0]            i_char,
    output scp_pkg::t_parse_state      o_state,
    output logic [15:0]                o_code
);

    // Subclass position: digit or zero, then scan unless luminosity is fixed
    function automatic scp_pkg::t_parse_state take_subclass(
        scp_pkg::t_parse_state s, logic [7:0] c);
        scp_pkg::t_parse_state n;
        n       = s;
        n.sub   = (c >= 8'h30 && c <= 8'h39) ? c[3:0] : 4'd0;
        n.phase = s.decided ? scp_pkg::PH_DONE : scp_pkg::PH_SCAN;
        return n;
    endfunction

    // Class letter decode
    function automatic scp_pkg::t_parse_state take_class(
        scp_pkg::t_parse_state s, logic [7:0] c);
        scp_pkg::t_parse_state n;
        n       = s;
        n.phase = scp_pkg::PH_SUB;
        case (c)
            8'h4F: n.cls = scp_pkg::CLS_O;   // 'O'
            8'h42: n.cls = scp_pkg::CLS_B;   // 'B'
            8'h41: n.cls = scp_pkg::CLS_A;   // 'A'
            8'h46: n.cls = scp_pkg::CLS_F;   // 'F'
            8'h47: n.cls = scp_pkg::CLS_G;   // 'G'
            8'h4B: n.cls = scp_pkg::CLS_K;   // 'K'
            8'h4D: n.cls = scp_pkg::CLS_M;   // 'M'
            8'h52: n.cls = scp_pkg::CLS_R;   // 'R'
            8'h53: n.cls = scp_pkg::CLS_S;   // 'S'
            8'h4E: n.cls = scp_pkg::CLS_N;   // 'N'
            8'h57: n.phase = scp_pkg::PH_W;  // 'W', wait for C or N
            8'h44: begin                     // 'D', white dwarf
                n.cls     = scp_pkg::CLS_DWARF;
                n.sub     = 4'd0;
                n.lum     = scp_pkg::LUM_IA0;
                n.decided = 1'b1;
                n.phase   = scp_pkg::PH_DONE;
            end
            default: n.cls = scp_pkg::CLS_UNKNOWN;
        endcase
        return n;
    endfunction

    // Luminosity fixed by the scan
    function automatic scp_pkg::t_parse_state decide(
        scp_pkg::t_parse_state s, logic [2:0] lum);
        scp_pkg::t_parse_state n;
        n         = s;
        n.lum     = lum;
        n.decided = 1'b1;
        n.phase   = scp_pkg::PH_DONE;
        return n;
    endfunction

    // Resolve whatever is pending as if the text ended here
    function automatic scp_pkg::t_parse_state finish(scp_pkg::t_parse_state s);
        scp_pkg::t_parse_state n;
        n = s;
        case (s.phase) inside
            scp_pkg::PH_FIRST, scp_pkg::PH_SD, scp_pkg::PH_CLASS, scp_pkg::PH_W: begin
                n.cls = scp_pkg::CLS_UNKNOWN;
                n.sub = 4'd0;
            end
            scp_pkg::PH_I:  n.lum = scp_pkg::LUM_IB;
            scp_pkg::PH_II: n.lum = scp_pkg::LUM_II;
            scp_pkg::PH_IA: n.lum = scp_pkg::LUM_IA;
            scp_pkg::PH_V:  n.lum = scp_pkg::LUM_V;
            default: ;
        endcase
        n.phase = scp_pkg::PH_DONE;
        return n;
    endfunction

    // One character through the phase decoder
    function automatic scp_pkg::t_parse_state feed(
        scp_pkg::t_parse_state s, logic [7:0] c);
        scp_pkg::t_parse_state n;
        n = s;
        if (s.pos < scp_pkg::POS_W'(scp_pkg::MAX_CHARS)) begin
            n.pos = s.pos + 1'b1;
        end
        unique case (s.phase)
            scp_pkg::PH_FIRST: begin
                if (c == 8'h73) n.phase = scp_pkg::PH_SD;   // 's'
                else            n = take_class(n, c);
            end
            scp_pkg::PH_SD: begin
                if (c == 8'h64) begin                       // 'd'
                    n.lum     = scp_pkg::LUM_VI;
                    n.decided = 1'b1;
                    n.phase   = scp_pkg::PH_CLASS;
                end else begin
                    n.cls = scp_pkg::CLS_UNKNOWN;
                    n     = take_subclass(n, c);
                end
            end
            scp_pkg::PH_CLASS: n = take_class(n, c);
            scp_pkg::PH_W: begin
                if (c == 8'h43) begin                       // 'C'
                    n.cls   = scp_pkg::CLS_WC;
                    n.phase = scp_pkg::PH_SUB;
                end else if (c == 8'h4E) begin              // 'N'
                    n.cls   = scp_pkg::CLS_WN;
                    n.phase = scp_pkg::PH_SUB;
                end else begin
                    n.cls = scp_pkg::CLS_UNKNOWN;
                    n     = take_subclass(n, c);
                end
            end
            scp_pkg::PH_SUB: n = take_subclass(n, c);
            scp_pkg::PH_SCAN: begin
                if (s.pos >= scp_pkg::POS_W'(scp_pkg::MAX_CHARS))
                    n.phase = scp_pkg::PH_DONE;
                else if (c == 8'h49) n.phase = scp_pkg::PH_I;  // 'I'
                else if (c == 8'h56) n.phase = scp_pkg::PH_V;  // 'V'
            end
            scp_pkg::PH_I: begin
                if      (c == 8'h49) n.phase = scp_pkg::PH_II;       // 'I'
                else if (c == 8'h56) n = decide(n, scp_pkg::LUM_IV);  // 'V'
                else if (c == 8'h61) n.phase = scp_pkg::PH_IA;       // 'a'
                else                 n = decide(n, scp_pkg::LUM_IB);
            end
            scp_pkg::PH_II:
                n = decide(n, (c == 8'h49) ? scp_pkg::LUM_III : scp_pkg::LUM_II);
            scp_pkg::PH_IA:
                n = decide(n, (c == 8'h30) ? scp_pkg::LUM_IA0 : scp_pkg::LUM_IA);
            scp_pkg::PH_V:
                n = decide(n, (c == 8'h49) ? scp_pkg::LUM_VI : scp_pkg::LUM_V);
            default: ;
        endcase
        return n;
    endfunction

    scp_pkg::t_parse_state w_fin;

    // NUL ends the text; nothing changes once the parse is done
    always_comb begin
        if (i_state.phase == scp_pkg::PH_DONE) begin
            o_state = i_state;
        end else if (i_char == 8'h00) begin
            o_state = finish(i_state);
        end else begin
            o_state = feed(i_state, i_char);
        end
        w_fin  = finish(o_state);
        o_code = {w_fin.cls, w_fin.sub, 1'b0, w_fin.lum};
    end

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the spectral class code packer: stimulus, prediction, checking.
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int PHASE_ITEMS  = 450;
    localparam int HOLD_AT      = 30;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int SEND_IDLE [4] = '{0, 70, 0, 13};
    localparam int RECV_STALL[4] = '{0, 0, 70, 13};

    typedef struct {
        bit [7:0] text_char;
        bit       last;
        bit       wait_drain;
    } t_char_word;

    logic i_clk;
    logic i_rst_n;

    scp_char_if char_bus ();
    scp_code_if code_bus ();

    spectral_class_code_packer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_code  (code_bus)
    );

    t_char_word  pending_chars[$];
    logic [15:0] codes_due[$];
    bit [7:0]    txt[$];

    int unsigned items_queued;
    int unsigned codes_checked;
    int unsigned mismatches;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned cycle_count;

    string lum_marks [9] = '{"I", "II", "III", "IV", "Ia0", "Ia", "Ib", "V", "VI"};
    string class_letters = "OBAFGKMRSNDW";
    string tail_marks    = "ep:+/ ";

    // Parser state mirrored by the predictor
    int unsigned scan_pos;
    logic [3:0]  scan_phase;
    logic [7:0]  cls_acc;
    logic [3:0]  sub_acc;
    logic [2:0]  lum_acc;
    bit          lum_fixed;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void restart_parse();
        scan_pos   = 0;
        scan_phase = scp_pkg::PH_FIRST;
        cls_acc    = scp_pkg::CLS_UNKNOWN;
        sub_acc    = 4'd0;
        lum_acc    = scp_pkg::LUM_V;
        lum_fixed  = 1'b0;
    endfunction

    function automatic void take_subclass_char(logic [7:0] c);
        sub_acc    = (c >= "0" && c <= "9") ? 4'(c - "0") : 4'd0;
        scan_phase = lum_fixed ? scp_pkg::PH_DONE : scp_pkg::PH_SCAN;
    endfunction

    function automatic void take_class_char(logic [7:0] c);
        scan_phase = scp_pkg::PH_SUB;
        case (c)
            "O": cls_acc = scp_pkg::CLS_O;
            "B": cls_acc = scp_pkg::CLS_B;
            "A": cls_acc = scp_pkg::CLS_A;
            "F": cls_acc = scp_pkg::CLS_F;
            "G": cls_acc = scp_pkg::CLS_G;
            "K": cls_acc = scp_pkg::CLS_K;
            "M": cls_acc = scp_pkg::CLS_M;
            "R": cls_acc = scp_pkg::CLS_R;
            "S": cls_acc = scp_pkg::CLS_S;
            "N": cls_acc = scp_pkg::CLS_N;
            "W": scan_phase = scp_pkg::PH_W;
            "D": begin
                // white dwarf: fixed code, rest of text ignored
                cls_acc    = scp_pkg::CLS_DWARF;
                sub_acc    = 4'd0;
                lum_acc    = scp_pkg::LUM_IA0;
                lum_fixed  = 1'b1;
                scan_phase = scp_pkg::PH_DONE;
            end
            default: cls_acc = scp_pkg::CLS_UNKNOWN;
        endcase
    endfunction

    function automatic void fix_luminosity(logic [2:0] l);
        lum_acc    = l;
        lum_fixed  = 1'b1;
        scan_phase = scp_pkg::PH_DONE;
    endfunction

    // settle whatever is pending as if the text stopped here
    function automatic void close_text();
        case (scan_phase) inside
            scp_pkg::PH_FIRST, scp_pkg::PH_SD, scp_pkg::PH_CLASS, scp_pkg::PH_W: begin
                cls_acc = scp_pkg::CLS_UNKNOWN;
                sub_acc = 4'd0;
            end
            scp_pkg::PH_I:  lum_acc = scp_pkg::LUM_IB;
            scp_pkg::PH_II: lum_acc = scp_pkg::LUM_II;
            scp_pkg::PH_IA: lum_acc = scp_pkg::LUM_IA;
            scp_pkg::PH_V:  lum_acc = scp_pkg::LUM_V;
            default: ;
        endcase
        scan_phase = scp_pkg::PH_DONE;
    endfunction

    function automatic void parse_char(logic [7:0] c, logic last);
        int unsigned at;
        at = scan_pos;
        if (scan_phase != scp_pkg::PH_DONE) begin
            if (c == 8'd0) begin
                close_text();
            end else begin
                if (scan_pos < scp_pkg::MAX_CHARS) scan_pos++;
                case (scan_phase)
                    scp_pkg::PH_FIRST: begin
                        if (c == "s") scan_phase = scp_pkg::PH_SD;
                        else take_class_char(c);
                    end
                    scp_pkg::PH_SD: begin
                        if (c == "d") begin
                            lum_acc    = scp_pkg::LUM_VI;
                            lum_fixed  = 1'b1;
                            scan_phase = scp_pkg::PH_CLASS;
                        end else begin
                            cls_acc = scp_pkg::CLS_UNKNOWN;
                            take_subclass_char(c);
                        end
                    end
                    scp_pkg::PH_CLASS: take_class_char(c);
                    scp_pkg::PH_W: begin
                        if (c == "C") begin
                            cls_acc    = scp_pkg::CLS_WC;
                            scan_phase = scp_pkg::PH_SUB;
                        end else if (c == "N") begin
                            cls_acc    = scp_pkg::CLS_WN;
                            scan_phase = scp_pkg::PH_SUB;
                        end else begin
                            cls_acc = scp_pkg::CLS_UNKNOWN;
                            take_subclass_char(c);
                        end
                    end
                    scp_pkg::PH_SUB: take_subclass_char(c);
                    scp_pkg::PH_SCAN: begin
                        // a mark may only start below the position limit
                        if (at >= scp_pkg::MAX_CHARS) scan_phase = scp_pkg::PH_DONE;
                        else if (c == "I") scan_phase = scp_pkg::PH_I;
                        else if (c == "V") scan_phase = scp_pkg::PH_V;
                    end
                    scp_pkg::PH_I: begin
                        if (c == "I") scan_phase = scp_pkg::PH_II;
                        else if (c == "V") fix_luminosity(scp_pkg::LUM_IV);
                        else if (c == "a") scan_phase = scp_pkg::PH_IA;
                        else fix_luminosity(scp_pkg::LUM_IB);
                    end
                    scp_pkg::PH_II:
                        fix_luminosity(c == "I" ? scp_pkg::LUM_III : scp_pkg::LUM_II);
                    scp_pkg::PH_IA:
                        fix_luminosity(c == "0" ? scp_pkg::LUM_IA0 : scp_pkg::LUM_IA);
                    scp_pkg::PH_V:
                        fix_luminosity(c == "I" ? scp_pkg::LUM_VI : scp_pkg::LUM_V);
                    default: ;
                endcase
            end
        end
        if (last) begin
            close_text();
            codes_due.push_back({cls_acc, sub_acc, 1'b0, lum_acc});
            restart_parse();
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus building
    // ---------------------------------------------------------------
    function automatic void txt_add(string s);
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    endfunction

    function automatic void txt_flush(bit drain);
        t_char_word w;
        foreach (txt[i]) begin
            w.text_char  = txt[i];
            w.last       = (i == txt.size() - 1);
            w.wait_drain = drain && (i == 0);
            pending_chars.push_back(w);
            items_queued++;
        end
        txt.delete();
    endfunction

    // spectral type text with random content, mostly well-formed
    function automatic void build_type();
        int unsigned r;
        bit [7:0]    cls_char;
        if ($urandom_range(99) < 15) txt_add("sd");
        cls_char = class_letters[$urandom_range(class_letters.len() - 1)];
        txt.push_back(cls_char);
        if (cls_char == "W") begin
            r = $urandom_range(9);
            if (r < 4) txt_add("C");
            else if (r < 8) txt_add("N");
            else txt.push_back(8'($urandom_range(255)));
        end
        r = $urandom_range(99);
        if (r < 80) txt.push_back(8'("0" + $urandom_range(9)));
        else if (r < 90) txt_add(".");
        // padding, sometimes long enough to cross the position limit
        r = $urandom_range(99);
        if (r < 12) repeat ($urandom_range(14, 4)) txt_add(" ");
        else if (r < 35) txt_add(" ");
        if ($urandom_range(99) < 85) txt_add(lum_marks[$urandom_range(8)]);
        if ($urandom_range(99) < 25)
            txt.push_back(tail_marks[$urandom_range(tail_marks.len() - 1)]);
    endfunction

    // ---------------------------------------------------------------
    // Clock and timeout
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("spectral_class_code_packer_top: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------
    // Driver: offers queued character words
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        bit offer;
        offer = 1'b0;
        if (!i_rst_n) begin
            char_bus.valid         <= 1'b0;
            char_bus.text_char     <= 8'd0;
            char_bus.end_of_string <= 1'b0;
        end else begin
            if (char_bus.valid && char_bus.ready) begin
                parse_char(char_bus.text_char, char_bus.end_of_string);
                void'(pending_chars.pop_front());
            end
            if (char_bus.valid && !char_bus.ready) begin
                offer = 1'b1;
            end else if (pending_chars.size() != 0) begin
                // pause point: hold back until every result is out
                if (pending_chars[0].wait_drain && codes_due.size() == 0
                        && !code_bus.valid)
                    pending_chars[0].wait_drain = 1'b0;
                offer = !pending_chars[0].wait_drain
                        && ($urandom_range(99) >= send_idle_pct);
            end
            char_bus.valid <= offer;
            if (offer) begin
                char_bus.text_char     <= pending_chars[0].text_char;
                char_bus.end_of_string <= pending_chars[0].last;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks result words, drives ready with stalls
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [15:0] want;
        logic [15:0] got;
        if (!i_rst_n) begin
            code_bus.ready <= 1'b0;
        end else begin
            if (code_bus.valid && code_bus.ready) begin
                got = code_bus.packed_type;
                codes_checked++;
                if (codes_due.size() == 0) begin
                    $error("packed_type: no result expected, got %h", got);
                    mismatches++;
                end else begin
                    want = codes_due.pop_front();
                    if (got !== want) begin
                        $error("packed_type: expected %h, got %h", want, got);
                        mismatches++;
                    end
                end
            end
            // one long hold-off so the block backs up into its input
            if (hold_left != 0) begin
                hold_left--;
                code_bus.ready <= 1'b0;
            end else if (!hold_done && codes_checked >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                code_bus.ready <= 1'b0;
            end else begin
                code_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence: reset, directed texts, random phases, end check
    // ---------------------------------------------------------------
    initial begin
        int unsigned target;
        bit          first;
        i_rst_n                = 1'b0;
        char_bus.valid         = 1'b0;
        char_bus.text_char     = 8'd0;
        char_bus.end_of_string = 1'b0;
        code_bus.ready         = 1'b0;
        items_queued   = 0;
        codes_checked  = 0;
        mismatches     = 0;
        hold_left      = 0;
        hold_done      = 1'b0;
        send_idle_pct  = SEND_IDLE[0];
        recv_stall_pct = RECV_STALL[0];
        restart_parse();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: prefix, Ia0, white dwarf, lone s, lone W, pending I,
        // WC, all-ones char, empty text
        txt_add("sdK7");  txt_flush(1'b0);
        txt_add("B2Ia0"); txt_flush(1'b0);
        txt_add("D");     txt_flush(1'b0);
        txt_add("sX");    txt_flush(1'b0);
        txt_add("WX");    txt_flush(1'b0);
        txt_add("WN9I");  txt_flush(1'b0);
        txt_add("WC8");   txt_flush(1'b0);
        txt.push_back(8'hFF); txt_flush(1'b0);
        txt.push_back(8'h00); txt_flush(1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            target = items_queued + PHASE_ITEMS;
            first  = 1'b1;
            while (items_queued < target) begin
                if ($urandom_range(99) < 10) begin
                    // noise: random bytes
                    repeat ($urandom_range(20, 1)) txt.push_back(8'($urandom_range(255)));
                end else begin
                    build_type();
                    if ($urandom_range(99) < 10)
                        txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
                    if ($urandom_range(99) < 4)
                        txt.insert($urandom_range(txt.size() - 1), 8'h00);
                end
                txt_flush(first || ($urandom_range(99) < 2));
                first = 1'b0;
            end
            while (pending_chars.size() != 0) @(posedge i_clk);
        end

        while (codes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("spectral_class_code_packer_top: match");
        else
            $display("spectral_class_code_packer_top: mismatch");
        $finish;
    end

endmodule
